FILE: design/mbssd_pkg.sv
// Shared types and constants for the multiplexed BCD seven-segment driver.
// Holds the digit position type, reciprocal constants and the segment decode.
// No dependencies.
package mbssd_pkg;

    typedef enum logic [1:0] {
        POS_THOUSANDS = 2'd0,
        POS_HUNDREDS  = 2'd1,
        POS_TENS      = 2'd2,
        POS_ONES      = 2'd3
    } pos_t;

    localparam int unsigned VALUE_W = 14;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned EN_W    = 4;

    localparam logic [VALUE_W-1:0] MAX_SHOWN = 14'd9999;

    // Reciprocals for exact constant division over 0..9999
    localparam logic [13:0] RECIP_1000 = 14'd8389;  // shift 23
    localparam logic [12:0] RECIP_100  = 13'd5243;  // shift 19
    localparam logic [12:0] RECIP_10   = 13'd6554;  // shift 16

    localparam logic [EN_W-1:0]  EN_ALL_OFF = 4'hF;
    localparam logic [SEG_W-1:0] SEG_BLANK  = 8'h00;

    // Segment pattern, bit6 = a down to bit0 = g, decimal point off
    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'h7E;
            4'd1:    seg = 8'h30;
            4'd2:    seg = 8'h6D;
            4'd3:    seg = 8'h79;
            4'd4:    seg = 8'h33;
            4'd5:    seg = 8'h5B;
            4'd6:    seg = 8'h5F;
            4'd7:    seg = 8'h70;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h7B;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

FILE: design/multiplexed_bcd_seven_segment_driver.sv
// Multiplexed four-digit seven-segment driver with BCD split and blanking.
// Top level; depends on mbssd_pkg.
//
// Usage:
//   Each transaction on the s_ channel is one refresh tick carrying a binary
//   value (s_tdata[13:0]). Values above 9999 are shown as 9999. A position
//   counter steps thousands, hundreds, tens, ones and wraps; every input
//   transaction yields exactly one m_ transaction for the current position:
//   the segment pattern, the active-low anode enables, the position and a
//   blank flag (m_tuser). Suppressed leading zeros drive segments 0 and all
//   anodes off; the ones digit is always shown.
//   Two registers lie between input and result: the first holds the
//   quotient picked for the position, the second the decoded result. One
//   transaction is accepted every cycle while the output is taken.
//   Reset clears the position counter to thousands and empties both stages.
//   When m_tready is low the result holds; one more item may enter the first
//   stage, then s_tready drops until the output drains.
module multiplexed_bcd_seven_segment_driver
    import mbssd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] value, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] segment_bits, [11:8] digit_enables,
                                   // [13:12] digit_position, [15:14] zero
    output logic        m_tuser    // [0] blanked
);

    pos_t               pos_reg;
    logic               p1_valid_reg;
    logic [VALUE_W-1:0] p1_quot_reg;
    logic               p1_show_reg;
    pos_t               p1_pos_reg;
    logic               m_valid_reg;
    logic [SEG_W-1:0]   m_seg_reg;
    logic [EN_W-1:0]    m_en_reg;
    pos_t               m_pos_reg;
    logic               m_blank_reg;

    logic               out_ready;
    logic               p1_ready;
    logic               s_accept;
    logic [VALUE_W-1:0] value_sat;
    logic [27:0]        prod_1000;
    logic [26:0]        prod_100;
    logic [26:0]        prod_10;
    logic [VALUE_W-1:0] quot_next;
    logic               show_next;
    logic [26:0]        prod_mod;
    logic [9:0]         quot_tail;
    logic [VALUE_W-1:0] digit_wide;
    logic [3:0]         digit;
    logic [SEG_W-1:0]   seg_next;
    logic [EN_W-1:0]    en_next;

    assign out_ready = !m_valid_reg || m_tready;
    assign p1_ready  = !p1_valid_reg || out_ready;
    assign s_tready  = p1_ready;
    assign s_accept  = s_tvalid && p1_ready;

    // Stage one: saturate and pick the quotient for the current position
    always_comb begin
        value_sat = (s_tdata[VALUE_W-1:0] > MAX_SHOWN) ? MAX_SHOWN : s_tdata[VALUE_W-1:0];
        prod_1000 = 28'(value_sat) * 28'(RECIP_1000);
        prod_100  = 27'(value_sat) * 27'(RECIP_100);
        prod_10   = 27'(value_sat) * 27'(RECIP_10);
        case (pos_reg)
            POS_THOUSANDS: begin
                quot_next = 14'(prod_1000[26:23]);
                show_next = value_sat >= 14'd1000;
            end
            POS_HUNDREDS: begin
                quot_next = 14'(prod_100[25:19]);
                show_next = value_sat >= 14'd100;
            end
            POS_TENS: begin
                quot_next = 14'(prod_10[25:16]);
                show_next = value_sat >= 14'd10;
            end
            default: begin
                quot_next = value_sat;
                show_next = 1'b1;
            end
        endcase
    end

    // Stage two: low decimal digit of the quotient, then decode or blank
    always_comb begin
        prod_mod   = 27'(p1_quot_reg) * 27'(RECIP_10);
        quot_tail  = prod_mod[25:16];
        digit_wide = p1_quot_reg - (14'({quot_tail, 3'b000}) + 14'({quot_tail, 1'b0}));
        digit      = digit_wide[3:0];
        seg_next   = p1_show_reg ? seg_decode(digit) : SEG_BLANK;
        en_next    = p1_show_reg ? ~(EN_W'(1) << p1_pos_reg) : EN_ALL_OFF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_THOUSANDS;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                pos_reg <= pos_t'(pos_reg + 2'd1);
            end
            if (p1_ready) begin
                p1_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    // Payload registers: load when the stage advances
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_quot_reg <= quot_next;
            p1_show_reg <= show_next;
            p1_pos_reg  <= pos_reg;
        end
        if (out_ready && p1_valid_reg) begin
            m_seg_reg   <= seg_next;
            m_en_reg    <= en_next;
            m_pos_reg   <= p1_pos_reg;
            m_blank_reg <= !p1_show_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_en_reg, m_seg_reg};
    assign m_tuser  = m_blank_reg;

    a_blank_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[11:8] == EN_ALL_OFF && m_tdata[7:0] == SEG_BLANK)
        else $error("blanked digit drives segments or anodes");

    a_shown_one_anode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> $onehot(~m_tdata[11:8]) && !m_tdata[7])
        else $error("shown digit without a single active anode");

    a_ones_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13:12] == POS_ONES |-> !m_tuser)
        else $error("ones digit blanked");

    a_anode_matches_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[8 + m_tdata[13:12]])
        else $error("active anode does not match digit position");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> pos_reg == pos_t'($past(pos_reg) + 2'd1))
        else $error("position counter did not advance on accepted transaction");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multiplexed_bcd_seven_segment_driver.
// Drives refresh ticks and predicts each untyped digit on its own. Depends on mbssd_pkg.
module tb
    import mbssd_pkg::*;
();

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_TICKS = 900;

    typedef struct packed {
        logic [7:0] segs;
        logic [3:0] anodes;
        pos_t       pos;
        logic       blank;
    } glyph_t;

    typedef struct packed {
        logic [13:0] value;
        logic        typed;
        glyph_t      want;
    } tick_row_t;

    localparam glyph_t NO_GLYPH = '{SEG_BLANK, EN_ALL_OFF, POS_THOUSANDS, 1'b0};

    // Rows land on thousands, hundreds, tens, ones in turn from reset
    localparam tick_row_t TICK_TABLE [24] = '{
        '{14'd0,     1'b1, '{8'h00, 4'hF, POS_THOUSANDS, 1'b1}},
        '{14'd0,     1'b1, '{8'h00, 4'hF, POS_HUNDREDS,  1'b1}},
        '{14'd0,     1'b1, '{8'h00, 4'hF, POS_TENS,      1'b1}},
        '{14'd0,     1'b1, '{8'h7E, 4'h7, POS_ONES,      1'b0}},
        '{14'd16383, 1'b1, '{8'h7B, 4'hE, POS_THOUSANDS, 1'b0}},
        '{14'd10000, 1'b1, '{8'h7B, 4'hD, POS_HUNDREDS,  1'b0}},
        '{14'd9999,  1'b1, '{8'h7B, 4'hB, POS_TENS,      1'b0}},
        '{14'd9,     1'b1, '{8'h7B, 4'h7, POS_ONES,      1'b0}},
        '{14'd999,   1'b1, '{8'h00, 4'hF, POS_THOUSANDS, 1'b1}},
        '{14'd99,    1'b1, '{8'h00, 4'hF, POS_HUNDREDS,  1'b1}},
        '{14'd9,     1'b1, '{8'h00, 4'hF, POS_TENS,      1'b1}},
        '{14'd10,    1'b1, '{8'h7E, 4'h7, POS_ONES,      1'b0}},
        '{14'd1000,  1'b0, NO_GLYPH},
        '{14'd100,   1'b0, NO_GLYPH},
        '{14'd10,    1'b0, NO_GLYPH},
        '{14'd1234,  1'b0, NO_GLYPH},
        '{14'd2345,  1'b0, NO_GLYPH},
        '{14'd3456,  1'b0, NO_GLYPH},
        '{14'd4567,  1'b0, NO_GLYPH},
        '{14'd5678,  1'b0, NO_GLYPH},
        '{14'd6789,  1'b0, NO_GLYPH},
        '{14'd7890,  1'b0, NO_GLYPH},
        '{14'd8901,  1'b0, NO_GLYPH},
        '{14'd9012,  1'b0, NO_GLYPH}
    };

    localparam logic [7:0] DIGIT_FONT [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    localparam logic [13:0] EDGE_VALUES [10] = '{
        14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000,
        14'd9998, 14'd9999, 14'd10000, 14'd16383
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic        m_tuser;

    pos_t   scan_pos = POS_THOUSANDS;
    glyph_t pending_glyphs [$];
    int     mismatches  = 0;
    int     idle_cycles = 0;
    logic [8:0] stall_phase = '0;

    multiplexed_bcd_seven_segment_driver DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Work out the digit shown for this tick and advance the scan position
    function automatic glyph_t scan_digit(input logic [13:0] value);
        glyph_t g;
        int     shown;
        int     digit;
        logic   lit;
        shown = (value > MAX_SHOWN) ? int'(MAX_SHOWN) : int'(value);
        case (scan_pos)
            POS_THOUSANDS: begin
                digit = (shown / 1000) % 10;
                lit   = digit != 0;
            end
            POS_HUNDREDS: begin
                digit = (shown / 100) % 10;
                lit   = shown >= 100;
            end
            POS_TENS: begin
                digit = (shown / 10) % 10;
                lit   = shown >= 10;
            end
            default: begin
                digit = shown % 10;
                lit   = 1'b1;
            end
        endcase
        g.pos = scan_pos;
        if (lit) begin
            g.segs   = DIGIT_FONT[digit];
            g.anodes = ~(4'b0001 << scan_pos);
            g.blank  = 1'b0;
        end else begin
            g.segs   = SEG_BLANK;
            g.anodes = EN_ALL_OFF;
            g.blank  = 1'b1;
        end
        scan_pos = pos_t'(scan_pos + 2'd1);
        return g;
    endfunction

    function automatic logic [13:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 14'($urandom_range(0, 16383));
            1:       return 14'($urandom_range(10000, 16383));
            2:       return 14'($urandom_range(0, 9));
            3:       return 14'($urandom_range(10, 99));
            4:       return 14'($urandom_range(100, 999));
            5:       return EDGE_VALUES[$urandom_range(0, 9)];
            default: return 14'($urandom_range(0, 9999));
        endcase
    endfunction

    // Hold the tick on the bus until it is taken, then record its digit
    task automatic send_tick(input logic [13:0] value, input logic typed,
                             input glyph_t want);
        glyph_t g;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        g = scan_digit(value);
        pending_glyphs.push_back(typed ? want : g);
    endtask

    always @(posedge aclk) begin : display_check
        glyph_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_glyphs.size() == 0) begin
                $error("unexpected result transaction: m_tdata %h m_tuser %b",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_glyphs.pop_front();
                if (m_tdata[7:0] !== want.segs) begin
                    $error("segment_bits expected %h got %h", want.segs, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[11:8] !== want.anodes) begin
                    $error("digit_enables expected %h got %h", want.anodes, m_tdata[11:8]);
                    mismatches++;
                end
                if (m_tdata[13:12] !== want.pos) begin
                    $error("digit_position expected %0d got %0d", want.pos, m_tdata[13:12]);
                    mismatches++;
                end
                if (m_tuser !== want.blank) begin
                    $error("blanked expected %b got %b", want.blank, m_tuser);
                    mismatches++;
                end
            end
        end
        // Rotate through always-ready, random and periodic stall patterns
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= $urandom_range(0, 4) != 0;
            default: m_tready <= stall_phase[2:0] != 3'd0;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multiplexed_bcd_seven_segment_driver regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int          sent;
        int          burst;
        int          gap;
        logic        paused;
        logic        hold;
        logic [13:0] v;
        sent   = 0;
        paused = 1'b0;
        hold   = 1'b0;
        v      = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (TICK_TABLE[i]) begin
            send_tick(TICK_TABLE[i].value, TICK_TABLE[i].typed, TICK_TABLE[i].want);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_glyphs.size() != 0) @(posedge aclk);

        while (sent < RANDOM_TICKS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++) begin
                // Mostly refresh a whole frame with one value, as a real display does
                if (b % 4 == 0) begin
                    v    = pick_value();
                    hold = $urandom_range(0, 2) != 0;
                end else if (!hold) begin
                    v = pick_value();
                end
                send_tick(v, 1'b0, NO_GLYPH);
                sent++;
            end
            if (sent >= RANDOM_TICKS / 2 && !paused) begin
                // Drain every outstanding digit before going on
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_glyphs.size() != 0) @(posedge aclk);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_glyphs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && pending_glyphs.size() == 0) begin
            $display("multiplexed_bcd_seven_segment_driver regression: pass");
        end else begin
            $display("multiplexed_bcd_seven_segment_driver regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mbssd_pkg.sv
design/multiplexed_bcd_seven_segment_driver.sv
dv/tb.sv
